[design/msb_pkg.sv]
// ----------------------------------------------------------------------------
// Shared stack buffer package
// Sizes, pointer types and operation codes for the multi-stack buffer.
// ----------------------------------------------------------------------------
package msb_pkg;

    // Number of stacks that share the store, and number of slots in the store.
    localparam int unsigned NUM_STACKS = 4;
    localparam int unsigned CAPACITY   = 64;

    // A slot index addresses the memories; a pointer can also hold the null code.
    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned PTR_W = $clog2(CAPACITY + 1);
    localparam int unsigned TOP_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    // Fixed field widths of the request and response.
    localparam int unsigned SID_W  = 2;
    localparam int unsigned DATA_W = 32;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [TOP_W-1:0]  t_top_idx;
    typedef logic [DATA_W-1:0] t_data;

    // The null link is encoded as the value CAPACITY.
    localparam t_ptr NULL_PTR = t_ptr'(CAPACITY);

    // Operation codes carried in the mode field.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

endpackage

[design/msb_if.sv]
// ----------------------------------------------------------------------------
// Shared stack buffer channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface msb_req_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic [msb_pkg::SID_W-1:0]          stack_id;
    logic signed [msb_pkg::DATA_W-1:0]  push_value;

    modport source (output valid, output mode, output stack_id, output push_value,
                    input ready);
    modport sink   (input valid, input mode, input stack_id, input push_value,
                    output ready);
endinterface

interface msb_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               success;
    logic signed [msb_pkg::DATA_W-1:0]  pop_value;

    modport source (output valid, output success, output pop_value, input ready);
    modport sink   (input valid, input success, input pop_value, output ready);
endinterface

[design/multi_stack_shared_buffer_unit.sv]
// ----------------------------------------------------------------------------
// Multi-stack shared buffer
// Several LIFO stacks kept in one slot store, with a linked free list.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on i_req: mode selects a push or a pop, stack_id
// names the stack and push_value carries the data of a push. Every request
// produces exactly one response on o_rsp, carrying a success flag and, for a
// successful pop, the popped value (zero otherwise). A push fails when every
// slot is in use; a pop fails when the addressed stack is empty; a failed
// request leaves all state untouched.
// Timing. A request is taken in the idle cycle and its response is loaded
// into the output register at the end of the following cycle, so o_rsp.valid
// rises as the update cycle ends. The block takes no new request while one is
// in its update cycle: the link word of the chosen slot comes from a
// synchronous memory read, and the head pointers can only be updated once
// that word is back.
// Reset clears the stack tops to empty, points the free list at slot zero
// and marks every link word as unwritten, so the initial free chain (slot i
// followed by slot i+1) is supplied without a clearing pass.
// Stalls. A response waits in the output register until o_rsp.ready is seen;
// a new request is taken while that response is being consumed, and the
// block holds i_req.ready low while the register is occupied and unread.
// ----------------------------------------------------------------------------
module multi_stack_shared_buffer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msb_req_if.sink   i_req,
    msb_rsp_if.source o_rsp
);

    // Two-phase sequencer: take a request and read memory, then update.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    // Head pointers.
    msb_pkg::t_ptr r_tops [msb_pkg::NUM_STACKS];
    msb_pkg::t_ptr r_free_head;

    // Slot memories. The link words carry a written flag per slot, so that an
    // unwritten slot reads as its reset link.
    msb_pkg::t_data r_val_mem  [msb_pkg::CAPACITY];
    msb_pkg::t_ptr  r_link_mem [msb_pkg::CAPACITY];
    logic [msb_pkg::CAPACITY-1:0] r_link_vld;

    // Registered read data.
    msb_pkg::t_data r_val_rd;
    msb_pkg::t_ptr  r_link_rd;
    logic           r_link_rd_vld;

    // Request held across the update cycle.
    logic              r_mode;
    logic              r_go;
    msb_pkg::t_ptr     r_slot;
    msb_pkg::t_top_idx r_tidx;
    msb_pkg::t_data    r_push_val;

    // Output register.
    logic           r_out_valid;
    logic           r_out_success;
    msb_pkg::t_data r_out_data;

    logic              req_accept;
    logic              sid_ok;
    msb_pkg::t_top_idx req_tidx;
    msb_pkg::t_ptr     top_sel;
    msb_pkg::t_ptr     slot_sel;
    logic              slot_ok;
    msb_pkg::t_idx     rd_idx;
    msb_pkg::t_idx     wr_idx;
    msb_pkg::t_ptr     link_now;
    logic              do_update;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign req_accept  = i_req.valid && i_req.ready;

    // Choose the slot: the free head for a push, the stack top for a pop.
    assign sid_ok   = (32'(i_req.stack_id) < 32'(msb_pkg::NUM_STACKS));
    assign req_tidx = msb_pkg::t_top_idx'(i_req.stack_id);
    assign top_sel  = r_tops[req_tidx];
    assign slot_sel = (i_req.mode == msb_pkg::MODE_POP) ? top_sel : r_free_head;
    assign slot_ok  = (slot_sel < msb_pkg::NULL_PTR);
    assign rd_idx   = slot_sel[msb_pkg::IDX_W-1:0];
    assign wr_idx   = r_slot[msb_pkg::IDX_W-1:0];

    // An unwritten slot still holds its reset link to the next slot; the last
    // slot thereby links to the null code.
    assign link_now  = r_link_rd_vld ? r_link_rd : (r_slot + msb_pkg::t_ptr'(1));
    assign do_update = (r_state == S_EXEC) && r_go;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory reads in the accept cycle, writes in the update cycle. The two
    // never touch the same slot in one cycle, as only one request is in flight.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_val_rd      <= r_val_mem[rd_idx];
            r_link_rd     <= r_link_mem[rd_idx];
            r_link_rd_vld <= r_link_vld[rd_idx];
        end
        if (do_update) begin
            if (r_mode == msb_pkg::MODE_PUSH) begin
                r_val_mem[wr_idx]  <= r_push_val;
                r_link_mem[wr_idx] <= r_tops[r_tidx];
            end else begin
                r_link_mem[wr_idx] <= r_free_head;
            end
        end
    end

    // Request payload held for the update cycle.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_mode     <= i_req.mode;
            r_go       <= sid_ok && slot_ok;
            r_slot     <= slot_sel;
            r_tidx     <= req_tidx;
            r_push_val <= i_req.push_value;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_out_success <= r_go;
            r_out_data    <= (r_go && (r_mode == msb_pkg::MODE_POP)) ? r_val_rd : '0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_free_head <= '0;
            r_link_vld  <= '0;
            for (int i = 0; i < int'(msb_pkg::NUM_STACKS); i++) begin
                r_tops[msb_pkg::t_top_idx'(i)] <= msb_pkg::NULL_PTR;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (do_update) begin
                r_link_vld[wr_idx] <= 1'b1;
                if (r_mode == msb_pkg::MODE_PUSH) begin
                    r_free_head    <= link_now;
                    r_tops[r_tidx] <= r_slot;
                end else begin
                    r_tops[r_tidx] <= link_now;
                    r_free_head    <= r_slot;
                end
            end
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.success   = r_out_success;
    assign o_rsp.pop_value = r_out_data;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter the update cycle");

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_IDLE) && r_out_valid)
        else $error("update cycle did not produce a response");

    a_no_accept_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !i_req.ready)
        else $error("request channel ready during the update cycle");

    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_success) |-> (r_out_data == '0))
        else $error("failed request returned non-zero data");

endmodule
